[rtl/core/btxq_pkg.sv]
package btxq_pkg;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_ERASE  = 3'd1,
    FN_FIND   = 3'd2,
    FN_XMIN   = 3'd3,
    FN_XMAX   = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_POOL_FULL = 3'd1,
    STAT_COUNT_OVF = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_COMMIT,
    S_DONE
  } state_e;

endpackage

[rtl/core/btxq_cell.sv]
module btxq_cell #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] rec_q;

  // one trie level of the recorded path, moves on by one cell per step
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= d_i;
    end
  end

  assign q_o = rec_q;

endmodule

[rtl/core/binary_trie_xor_query.sv]
// Binary trie over a multiset of keys with insert, erase, find and xor min/max
// queries, plus a clear request.
// Input channel: in_valid_i / in_stall_o with func_i and key_i. An item is
// taken when valid is high and stall is low; stall stays high while an item
// is being worked on.
// Output channel: out_valid_o / out_stall_i with xor_value_o, found_o and
// status_o, one result per item.
// Timing: a walk handles one key bit per cycle, each a single read of the node
// memory with the link taken from the previous read. Find and xor queries go
// from the walk to a check step and then to the result. Insert and erase add a
// second pass that writes the path back from a row of cells that captured it
// during the walk. Clear and unknown functions skip the walk and go straight
// to the result. Rejected inserts and erases end after the walk.
// Reset leaves the trie empty with only the root in use; node memory is not
// cleared, a node is fully written when it is allocated.
// When the receiver stalls, the result stays in the output register and the
// next item is still taken and walked; it waits in its last step until the
// output register is free.
module binary_trie_xor_query import btxq_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] xor_value_o,
  output logic        found_o,
  output logic [2:0]  status_o
);

  localparam int NB = $clog2(NODE_COUNT);
  localparam int CB = COUNT_BITS;
  localparam int EW = 2 * NB + 2 * CB;
  localparam int RW = NB + EW;
  localparam int LW = $clog2(KEY_BITS + 1);
  localparam logic [NB-1:0] ROOT    = NB'(1);
  localparam logic [CB-1:0] CMAX    = '1;
  localparam logic [NB:0]   LAST    = (NB + 1)'(NODE_COUNT - 1);
  localparam logic [LW-1:0] LVL_END = LW'(KEY_BITS - 1);

  // entry layout: link1, link0, count1, count0 (counts are of the children)
  function automatic logic [NB-1:0] f_link(input logic [EW-1:0] e, input logic s);
    return s ? e[2*CB+NB +: NB] : e[2*CB +: NB];
  endfunction

  function automatic logic [CB-1:0] f_cnt(input logic [EW-1:0] e, input logic s);
    return s ? e[CB +: CB] : e[0 +: CB];
  endfunction

  function automatic logic [EW-1:0] f_set(input logic [EW-1:0] e, input logic s,
                                          input logic [NB-1:0] lk,
                                          input logic [CB-1:0] ct);
    logic [EW-1:0] r;
    r = e;
    if (s) begin
      r[2*CB+NB +: NB] = lk;
      r[CB +: CB]      = ct;
    end else begin
      r[2*CB +: NB] = lk;
      r[0 +: CB]    = ct;
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic [2:0]         func_q, func_d;
  logic [KEY_BITS-1:0] key_q, key_d, key_sh_q, key_sh_d, acc_q, acc_d;
  logic [NB-1:0]      addr_q, addr_d, nf_q, nf_d, alloc_q, alloc_d;
  logic [EW-1:0]      root_q, root_d, rd_q;
  logic [LW-1:0]      need_q, need_d;
  logic               ovf_q, ovf_d, miss_q, miss_d;
  logic [31:0]        res_xv_q, res_xv_d, out_xv_q, out_xv_d;
  logic               res_found_q, res_found_d, out_found_q, out_found_d;
  status_e            res_status_q, res_status_d, out_status_q, out_status_d;
  logic               out_valid_q, out_valid_d;

  logic [EW-1:0]      mem_q [NODE_COUNT];
  logic               mem_we;
  logic [NB-1:0]      raddr;

  logic [EW-1:0]      ent, base, wdata;
  logic               bit_cur, want_max, pref, take, is_query, dir;
  logic [NB-1:0]      walk_lk, c_node, tgt, c_lk, new_node, wlk;
  logic [CB-1:0]      walk_ct, c_ct, wct;
  logic [RW-1:0]      rec_in;
  logic [RW-1:0]      chain [KEY_BITS];
  logic               shift_en;

  // node view for the address read last cycle; root lives in flops
  always_comb begin
    if (addr_q == ROOT) begin
      ent = root_q;
    end else if (addr_q == '0) begin
      ent = '0;
    end else begin
      ent = rd_q;
    end
    bit_cur  = key_sh_q[KEY_BITS-1];
    want_max = (func_q == FN_XMAX);
    pref     = bit_cur ^ want_max;
    take     = (f_cnt(ent, pref) != '0) ? pref : ~pref;
    is_query = (func_q == FN_XMIN) || (func_q == FN_XMAX);
    dir      = is_query ? take : bit_cur;
    walk_lk  = f_link(ent, bit_cur);
    walk_ct  = f_cnt(ent, bit_cur);
    raddr    = f_link(ent, dir);
  end

  assign rec_in   = {addr_q, ent};
  assign shift_en = (state_q == S_WALK) || (state_q == S_COMMIT);

  for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
    if (i == 0) begin : g_head
      btxq_cell #(.W(RW)) u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .d_i     (rec_in),
        .q_o     (chain[i])
      );
    end else begin : g_body
      btxq_cell #(.W(RW)) u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .d_i     (chain[i-1]),
        .q_o     (chain[i])
      );
    end
  end

  // write-back of one path level; a level past the end of the old path is new
  always_comb begin
    c_node   = chain[KEY_BITS-1][RW-1 -: NB];
    base     = (c_node != '0) ? chain[KEY_BITS-1][EW-1:0] : '0;
    tgt      = (c_node != '0) ? c_node : alloc_q;
    c_lk     = f_link(base, bit_cur);
    c_ct     = f_cnt(base, bit_cur);
    new_node = nf_q + NB'(1);
    if (func_q == FN_INSERT) begin
      if (c_lk == '0) begin
        wlk = new_node;
        wct = CB'(1);
      end else begin
        wlk = c_lk;
        wct = c_ct + CB'(1);
      end
    end else begin
      wlk = c_lk;
      wct = c_ct - CB'(1);
    end
    wdata = f_set(base, bit_cur, wlk, wct);
  end

  always_comb begin
    state_d      = state_q;
    lvl_d        = lvl_q;
    func_d       = func_q;
    key_d        = key_q;
    key_sh_d     = key_sh_q;
    acc_d        = acc_q;
    addr_d       = addr_q;
    nf_d         = nf_q;
    alloc_d      = alloc_q;
    root_d       = root_q;
    need_d       = need_q;
    ovf_d        = ovf_q;
    miss_d       = miss_q;
    res_xv_d     = res_xv_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_xv_d     = out_xv_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d       = func_i;
          key_d        = key_i[KEY_BITS-1:0];
          key_sh_d     = key_i[KEY_BITS-1:0];
          addr_d       = ROOT;
          lvl_d        = '0;
          need_d       = '0;
          ovf_d        = 1'b0;
          miss_d       = 1'b0;
          acc_d        = '0;
          res_xv_d     = '0;
          res_found_d  = 1'b0;
          res_status_d = STAT_OK;
          priority if (func_i == FN_CLEAR) begin
            nf_d    = ROOT;
            root_d  = '0;
            state_d = S_DONE;
          end else if (func_i > FN_CLEAR) begin
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        need_d   = need_q + LW'(walk_lk == '0);
        ovf_d    = ovf_q || ((walk_lk != '0) && (walk_ct == CMAX));
        miss_d   = miss_q || (walk_ct == '0);
        acc_d    = (acc_q << 1) | KEY_BITS'(take != bit_cur);
        addr_d   = raddr;
        key_sh_d = key_sh_q << 1;
        lvl_d    = lvl_q + LW'(1);
        if (lvl_q == LVL_END) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        key_sh_d = key_q;
        lvl_d    = '0;
        state_d  = S_DONE;
        case (func_q)
          FN_INSERT: begin
            priority if ((LAST - {1'b0, nf_q}) < (NB + 1)'(need_q)) begin
              res_status_d = STAT_POOL_FULL;
            end else if (ovf_q) begin
              res_status_d = STAT_COUNT_OVF;
            end else begin
              state_d = S_COMMIT;
            end
          end
          FN_ERASE: begin
            if (miss_q) begin
              res_status_d = STAT_NOT_FOUND;
            end else begin
              state_d = S_COMMIT;
            end
          end
          FN_FIND: begin
            res_found_d = !miss_q;
          end
          FN_XMIN, FN_XMAX: begin
            if ((f_cnt(root_q, 1'b0) == '0) && (f_cnt(root_q, 1'b1) == '0)) begin
              res_status_d = STAT_EMPTY;
            end else begin
              res_xv_d = 32'(acc_q);
            end
          end
          default: begin
            res_status_d = STAT_OK;
          end
        endcase
      end
      S_COMMIT: begin
        if (tgt == ROOT) begin
          root_d = wdata;
        end else begin
          mem_we = 1'b1;
        end
        if ((func_q == FN_INSERT) && (c_lk == '0)) begin
          nf_d    = new_node;
          alloc_d = new_node;
        end
        key_sh_d = key_sh_q << 1;
        lvl_d    = lvl_q + LW'(1);
        if (lvl_q == LVL_END) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_xv_d     = res_xv_q;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      nf_q        <= ROOT;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      nf_q        <= nf_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    key_sh_q     <= key_sh_d;
    acc_q        <= acc_d;
    addr_q       <= addr_d;
    alloc_q      <= alloc_d;
    need_q       <= need_d;
    ovf_q        <= ovf_d;
    miss_q       <= miss_d;
    res_xv_q     <= res_xv_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_xv_q     <= out_xv_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tgt] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign xor_value_o = out_xv_q;
  assign found_o     = out_found_q;
  assign status_o    = out_status_q;

endmodule

[rtl/core/btxq_checker.sv]
module btxq_checker import btxq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] xor_value_o,
  input logic        found_o,
  input logic [2:0]  status_o
);

  // a result held by the receiver does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(xor_value_o)
      && $stable(found_o) && $stable(status_o))
    else $error("output item changed while stalled");

  // an accepted item keeps the input side closed for its work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == STAT_OK && xor_value_o == 32'd0)
    else $error("found set with bad status or xor value");

  a_xor_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && xor_value_o != 32'd0 |-> status_o == STAT_OK && !found_o)
    else $error("xor value reported on failed item");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STAT_OK || status_o == STAT_POOL_FULL
      || status_o == STAT_COUNT_OVF || status_o == STAT_NOT_FOUND
      || status_o == STAT_EMPTY)
    else $error("status code out of range");

endmodule

bind binary_trie_xor_query btxq_checker u_btxq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .xor_value_o (xor_value_o),
  .found_o     (found_o),
  .status_o    (status_o)
);
